// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: ante implies cons");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: ante then cons");

`endif

// ===== rtl/wdms_pkg.sv =====
// ----------------------------------------------------------------------------
// wdms_pkg
// Shared types and constants of the wildcard driver match selector.
// ----------------------------------------------------------------------------
package wdms_pkg;

    localparam int MAX_RULES_DEF = 16;

    localparam logic [15:0] WILD16 = 16'hFFFF;
    localparam logic [7:0]  WILD8  = 8'hFF;

    localparam logic [4:0] W_VENDOR = 5'd16;
    localparam logic [4:0] W_DEVICE = 5'd8;
    localparam logic [4:0] W_CLASS  = 5'd4;
    localparam logic [4:0] W_SUB    = 5'd2;
    localparam logic [4:0] W_PIF    = 5'd1;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [15:0] vendor;
        logic [15:0] device;
        logic [7:0]  cls;
        logic [7:0]  sub;
        logic [7:0]  pif;
    } dev_id_t;

    typedef struct packed {
        logic [7:0] prio;
        dev_id_t    fields;
    } rule_t;

    typedef struct packed {
        logic       hit;
        logic [4:0] spec;
    } match_res_t;

endpackage

// ===== rtl/wildcard_driver_match_selector.sv =====
// ----------------------------------------------------------------------------
// wildcard_driver_match_selector
// Wildcard rule table with a best-match lookup over the loaded rules.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake               Contents
//  --------  ----------------------  ---------------------------------------
//  in        in_valid / in_ready     req_type, entry_index, identity, priority
//  out       out_valid / out_ready   found, best_index, best_spec, best_prio
//  cfg       cfg_wr_en               cfg_wr_data -> active_entries
//
//  A load transaction writes the rule at the accept edge. A lookup scans
//  min(active_entries, MAX_RULES) rules through the single read port of the
//  rule memory, one rule per cycle; a zero scan goes straight to the result.
//  Reset clears the sequencer and sets active_entries to 1; the rule memory
//  is not cleared. A stalled result waits in the output register; loads are
//  still taken meanwhile, and a finished lookup holds until that register
//  frees.
// ----------------------------------------------------------------------------
module wildcard_driver_match_selector #(
    parameter int MAX_RULES = wdms_pkg::MAX_RULES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic [3:0]  entry_index,
    input  logic [15:0] vendor_code,
    input  logic [15:0] device_code,
    input  logic [7:0]  base_class,
    input  logic [7:0]  subclass,
    input  logic [7:0]  prog_if,
    input  logic [7:0]  priority_req,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        found,
    output logic [3:0]  best_index,
    output logic [4:0]  best_spec,
    output logic [7:0]  best_prio
);
    import wdms_pkg::*;

    // address width of the rule memory
    localparam int AW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;

    logic [4:0]    active_reg;
    dev_id_t       in_dev;
    dev_id_t       dev;
    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    rule_t         mem_wr_data;
    logic          mem_rd_en;
    logic [AW-1:0] mem_rd_addr;
    rule_t         mem_rd_data;
    match_res_t    mres;

    // Hold the scan length; the user must write it only while idle, unenforced.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 5'd1;
        end
        else if (cfg_wr_en)
        begin
            active_reg <= cfg_wr_data;
        end
    end

    // Gather the identity fields; a load stores them as the rule itself.
    assign in_dev = '{vendor: vendor_code, device: device_code, cls: base_class,
                      sub: subclass, pif: prog_if};

    // Rule memory: rule fields and priority share one word.
    wdms_rule_mem #(
        .DEPTH (MAX_RULES),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Compare the rule read in the previous cycle with the held identity.
    wdms_match u_match (
        .rule (mem_rd_data.fields),
        .dev  (dev),
        .res  (mres)
    );

    // Sequence transactions, advance the scan and keep the best rule.
    wdms_ctrl #(
        .MAX_RULES (MAX_RULES),
        .AW        (AW)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .entry_index    (entry_index),
        .in_dev         (in_dev),
        .priority_req   (priority_req),
        .active_entries (active_reg),
        .mem_wr_en      (mem_wr_en),
        .mem_wr_addr    (mem_wr_addr),
        .mem_wr_data    (mem_wr_data),
        .mem_rd_en      (mem_rd_en),
        .mem_rd_addr    (mem_rd_addr),
        .rd_prio        (mem_rd_data.prio),
        .mres           (mres),
        .dev            (dev),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .found          (found),
        .best_index     (best_index),
        .best_spec      (best_spec),
        .best_prio      (best_prio)
    );

endmodule

// ===== rtl/wdms_rule_mem.sv =====
// ----------------------------------------------------------------------------
// wdms_rule_mem
// Rule store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module wdms_rule_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  wdms_pkg::rule_t   wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output wdms_pkg::rule_t   rd_data
);
    import wdms_pkg::*;

    rule_t mem [DEPTH];
    rule_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/wdms_match.sv =====
// ----------------------------------------------------------------------------
// wdms_match
// Compare one rule with a device identity and weigh its specificity.
// ----------------------------------------------------------------------------
module wdms_match (
    input  wdms_pkg::dev_id_t    rule,
    input  wdms_pkg::dev_id_t    dev,
    output wdms_pkg::match_res_t res
);
    import wdms_pkg::*;

    logic wv, wd, wc, ws, wp;

    always_comb
    begin
        wv = (rule.vendor == WILD16);
        wd = (rule.device == WILD16);
        wc = (rule.cls == WILD8);
        ws = (rule.sub == WILD8);
        wp = (rule.pif == WILD8);
        res.hit = (wv || rule.vendor == dev.vendor) &&
                  (wd || rule.device == dev.device) &&
                  (wc || rule.cls == dev.cls) &&
                  (ws || rule.sub == dev.sub) &&
                  (wp || rule.pif == dev.pif);
        res.spec = (wv ? 5'd0 : W_VENDOR) + (wd ? 5'd0 : W_DEVICE) +
                   (wc ? 5'd0 : W_CLASS) + (ws ? 5'd0 : W_SUB) +
                   (wp ? 5'd0 : W_PIF);
    end

endmodule

// ===== rtl/wdms_ctrl.sv =====
// ----------------------------------------------------------------------------
// wdms_ctrl
// Transaction sequencer: rule loads, lookup scan and best-rule tracking.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wdms_ctrl #(
    parameter int MAX_RULES = 16,
    parameter int AW        = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  req_type,
    input  logic [3:0]            entry_index,
    input  wdms_pkg::dev_id_t     in_dev,
    input  logic [7:0]            priority_req,
    input  logic [4:0]            active_entries,
    output logic                  mem_wr_en,
    output logic [AW-1:0]         mem_wr_addr,
    output wdms_pkg::rule_t       mem_wr_data,
    output logic                  mem_rd_en,
    output logic [AW-1:0]         mem_rd_addr,
    input  logic [7:0]            rd_prio,
    input  wdms_pkg::match_res_t  mres,
    output wdms_pkg::dev_id_t     dev,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  found,
    output logic [3:0]            best_index,
    output logic [4:0]            best_spec,
    output logic [7:0]            best_prio
);
    import wdms_pkg::*;

    localparam int CW    = $clog2(MAX_RULES + 1);
    localparam int LIM_W = (CW > 5) ? CW : 5;

    state_t          state_reg, state_next;
    logic [AW-1:0]   idx_reg, idx_next;
    logic [CW-1:0]   lim_reg, lim_next;
    dev_id_t         dev_reg, dev_next;
    logic            bfound_reg, bfound_next;
    logic [AW-1:0]   bidx_reg, bidx_next;
    logic [4:0]      bspec_reg, bspec_next;
    logic [7:0]      bpri_reg, bpri_next;
    logic            ovalid_reg, ovalid_next;
    logic            ofound_reg, ofound_next;
    logic [3:0]      oidx_reg, oidx_next;
    logic [4:0]      ospec_reg, ospec_next;
    logic [7:0]      opri_reg, opri_next;

    logic            accept;
    logic            last;
    logic [LIM_W-1:0] act_ext;
    logic [CW-1:0]   lim_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        lim_reg    <= lim_next;
        dev_reg    <= dev_next;
        bfound_reg <= bfound_next;
        bidx_reg   <= bidx_next;
        bspec_reg  <= bspec_next;
        bpri_reg   <= bpri_next;
        ofound_reg <= ofound_next;
        oidx_reg   <= oidx_next;
        ospec_reg  <= ospec_next;
        opri_reg   <= opri_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        lim_next    = lim_reg;
        dev_next    = dev_reg;
        bfound_next = bfound_reg;
        bidx_next   = bidx_reg;
        bspec_next  = bspec_reg;
        bpri_next   = bpri_reg;
        ovalid_next = ovalid_reg && !out_ready;
        ofound_next = ofound_reg;
        oidx_next   = oidx_reg;
        ospec_next  = ospec_reg;
        opri_next   = opri_reg;

        in_ready = (state_reg == ST_IDLE);
        accept   = in_valid && in_ready;
        last     = (CW'(idx_reg) + CW'(1)) == lim_reg;

        // clamp the scan length to the table depth
        act_ext = LIM_W'(active_entries);
        if (act_ext > LIM_W'(MAX_RULES))
        begin
            lim_in = CW'(MAX_RULES);
        end
        else
        begin
            lim_in = CW'(act_ext);
        end

        mem_wr_en   = accept && (req_type == REQ_LOAD) && (int'(entry_index) < MAX_RULES);
        mem_wr_addr = AW'(entry_index);
        mem_wr_data = '{prio: priority_req, fields: in_dev};
        mem_rd_en   = 1'b0;
        mem_rd_addr = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && req_type == REQ_LOOKUP)
                begin
                    dev_next    = in_dev;
                    lim_next    = lim_in;
                    idx_next    = '0;
                    bfound_next = 1'b0;
                    bidx_next   = '0;
                    bspec_next  = '0;
                    bpri_next   = '0;
                    if (lim_in == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        mem_rd_en  = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (mres.hit && (!bfound_reg || mres.spec > bspec_reg ||
                                 (mres.spec == bspec_reg && rd_prio > bpri_reg)))
                begin
                    bfound_next = 1'b1;
                    bidx_next   = idx_reg;
                    bspec_next  = mres.spec;
                    bpri_next   = rd_prio;
                end
                if (last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next    = idx_reg + AW'(1);
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = idx_reg + AW'(1);
                end
            end
            ST_DONE:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    ovalid_next = 1'b1;
                    ofound_next = bfound_reg;
                    oidx_next   = 4'(bidx_reg);
                    ospec_next  = bspec_reg;
                    opri_next   = bpri_reg;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign dev        = dev_reg;
    assign out_valid  = ovalid_reg;
    assign found      = ofound_reg;
    assign best_index = oidx_reg;
    assign best_spec  = ospec_reg;
    assign best_prio  = opri_reg;

    `ASSERT_IMPLIES(a_scan_in_range, state_reg == ST_SCAN, CW'(idx_reg) < lim_reg)
    `ASSERT_NEXT(a_scan_ends_done, state_reg == ST_SCAN && last, state_reg == ST_DONE)
    `ASSERT_IMPLIES(a_miss_is_zero, ovalid_reg && !ofound_reg,
                    oidx_reg == '0 && ospec_reg == '0 && opri_reg == '0)
    `ASSERT_NEXT(a_lookup_starts, accept && req_type == REQ_LOOKUP,
                 !bfound_reg && (state_reg == ST_SCAN || state_reg == ST_DONE))

endmodule

// ===== tb/wildcard_driver_match_selector_tb.sv =====
// ----------------------------------------------------------------------------
// wildcard_driver_match_selector_tb
// Self-checking bench for the wildcard rule table and its best-match lookup.
// Fills every rule slot first, then runs a short directed set and several
// random phases under different scan counts. Random stalls and gaps are
// applied on both channels. Every lookup is predicted and its result checked
// in order.
// ----------------------------------------------------------------------------
module wildcard_driver_match_selector_tb;

    import wdms_pkg::*;

    // A scan of 16 rules plus the pipeline overhead, with some margin.
    localparam int SETTLE_CYCLES   = MAX_RULES_DEF + 4;
    localparam int ITEMS_PER_PHASE = 240;
    localparam int NUM_PHASES      = 8;

    // One input transaction, as the sender presents it.
    typedef struct packed {
        logic       req;
        logic [3:0] slot;
        dev_id_t    id;
        logic [7:0] prio;
    } rule_req_t;

    // One result transaction.
    typedef struct packed {
        logic       found;
        logic [3:0] index;
        logic [4:0] spec;
        logic [7:0] prio;
    } match_report_t;

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of the rule table and the scan count, plus the
    // queue of lookup results still owed by the block.
    // ------------------------------------------------------------------------
    class match_scoreboard;
        dev_id_t       rules [MAX_RULES_DEF];
        logic [7:0]    prios [MAX_RULES_DEF];
        logic [4:0]    scan_count;
        match_report_t owed_reports [$];
        int            errors;

        function new();
            scan_count = 5'd1;
            errors     = 0;
        endfunction

        function void set_scan_count(logic [4:0] value);
            scan_count = value;
        endfunction

        function int pending();
            return owed_reports.size();
        endfunction

        // Best rule for a device: highest specificity, then strictly higher
        // priority, so the earliest slot wins a full tie.
        function match_report_t best_match(dev_id_t who);
            match_report_t best;
            dev_id_t       r;
            int            limit;
            logic [4:0]    spec;
            logic          hit;
            best  = '0;
            limit = (scan_count > MAX_RULES_DEF) ? MAX_RULES_DEF : int'(scan_count);
            for (int i = 0; i < limit; i++)
            begin
                r   = rules[i];
                hit = (r.vendor == WILD16 || r.vendor == who.vendor) &&
                      (r.device == WILD16 || r.device == who.device) &&
                      (r.cls == WILD8 || r.cls == who.cls) &&
                      (r.sub == WILD8 || r.sub == who.sub) &&
                      (r.pif == WILD8 || r.pif == who.pif);
                if (!hit)
                    continue;
                spec = 5'd0;
                if (r.vendor != WILD16) spec += W_VENDOR;
                if (r.device != WILD16) spec += W_DEVICE;
                if (r.cls != WILD8)     spec += W_CLASS;
                if (r.sub != WILD8)     spec += W_SUB;
                if (r.pif != WILD8)     spec += W_PIF;
                if (!best.found || spec > best.spec ||
                    (spec == best.spec && prios[i] > best.prio))
                begin
                    best.found = 1'b1;
                    best.index = 4'(i);
                    best.spec  = spec;
                    best.prio  = prios[i];
                end
            end
            return best;
        endfunction

        // Note an accepted input transaction: loads update the table,
        // lookups queue their predicted result.
        function void note_request(rule_req_t item);
            if (item.req == REQ_LOAD)
            begin
                rules[item.slot] = item.id;
                prios[item.slot] = item.prio;
            end
            else
                owed_reports.push_back(best_match(item.id));
        endfunction

        // Check an accepted result against the oldest prediction.
        function void check_report(match_report_t got);
            match_report_t want;
            if (owed_reports.size() == 0)
            begin
                $display("%0t: unexpected result found=%0d index=%0d spec=%0d prio=%0d",
                         $time, got.found, got.index, got.spec, got.prio);
                errors++;
                return;
            end
            want = owed_reports.pop_front();
            if (got.found !== want.found || got.index !== want.index ||
                got.spec !== want.spec || got.prio !== want.prio)
            begin
                $display("%0t: mismatch expected found=%0d index=%0d spec=%0d prio=%0d",
                         $time, want.found, want.index, want.spec, want.prio);
                $display("%0t:          actual   found=%0d index=%0d spec=%0d prio=%0d",
                         $time, got.found, got.index, got.spec, got.prio);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block inputs, all known from time zero.
    // ------------------------------------------------------------------------
    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_wr_en    = 1'b0;
    logic [4:0]  cfg_wr_data  = '0;
    logic        in_valid     = 1'b0;
    logic        req_type     = REQ_LOAD;
    logic [3:0]  entry_index  = '0;
    logic [15:0] vendor_code  = '0;
    logic [15:0] device_code  = '0;
    logic [7:0]  base_class   = '0;
    logic [7:0]  subclass     = '0;
    logic [7:0]  prog_if      = '0;
    logic [7:0]  priority_req = '0;
    logic        out_ready    = 1'b0;

    logic        in_ready;
    logic        out_valid;
    logic        found;
    logic [3:0]  best_index;
    logic [4:0]  best_spec;
    logic [7:0]  best_prio;

    // Idle controls for the current phase: quiet means no gaps or stalls.
    logic        tx_quiet = 1'b0;
    logic        rx_quiet = 1'b0;

    dev_id_t         id_pool [4];
    match_report_t   seen_report;
    match_scoreboard sb = new();

    always #5 clk = ~clk;

    wildcard_driver_match_selector dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .entry_index  (entry_index),
        .vendor_code  (vendor_code),
        .device_code  (device_code),
        .base_class   (base_class),
        .subclass     (subclass),
        .prog_if      (prog_if),
        .priority_req (priority_req),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .found        (found),
        .best_index   (best_index),
        .best_spec    (best_spec),
        .best_prio    (best_prio)
    );

    // Gap length: mostly none or short, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Rule identity drawn from the pool, with wildcards and odd values mixed
    // in so that several rules overlap on the same device.
    function automatic dev_id_t make_rule_id();
        dev_id_t base;
        dev_id_t id;
        base = id_pool[$urandom_range(0, 3)];
        id   = base;
        case ($urandom_range(0, 9))
            0, 1, 2: id.vendor = WILD16;
            3:       id.vendor = 16'($urandom);
            default: id.vendor = base.vendor;
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2: id.device = WILD16;
            3:       id.device = 16'($urandom);
            default: id.device = base.device;
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2: id.cls = WILD8;
            3:       id.cls = 8'($urandom);
            default: id.cls = base.cls;
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2: id.sub = WILD8;
            3:       id.sub = 8'($urandom);
            default: id.sub = base.sub;
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2: id.pif = WILD8;
            3:       id.pif = 8'($urandom);
            default: id.pif = base.pif;
        endcase
        return id;
    endfunction

    // Device identity for a lookup: mostly a pool device, sometimes noise.
    function automatic dev_id_t make_probe_id();
        dev_id_t id;
        if ($urandom_range(0, 4) == 0)
            return dev_id_t'(56'({$urandom, $urandom}));
        id = id_pool[$urandom_range(0, 3)];
        if ($urandom_range(0, 9) == 0) id.vendor = 16'($urandom);
        if ($urandom_range(0, 9) == 0) id.device = 16'($urandom);
        if ($urandom_range(0, 9) == 0) id.cls    = 8'($urandom);
        if ($urandom_range(0, 9) == 0) id.sub    = 8'($urandom);
        if ($urandom_range(0, 9) == 0) id.pif    = 8'($urandom);
        return id;
    endfunction

    // Present one transaction and hold it until accepted. Called at a
    // rising edge; returns at the accepting edge with in_valid still high,
    // so a back-to-back transaction needs only one assignment to in_valid.
    task automatic send(rule_req_t item);
        int g;
        g = tx_quiet ? 0 : gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= item.req;
        entry_index  <= item.slot;
        vendor_code  <= item.id.vendor;
        device_code  <= item.id.device;
        base_class   <= item.id.cls;
        subclass     <= item.id.sub;
        prog_if      <= item.id.pif;
        priority_req <= item.prio;
        do @(posedge clk); while (!in_ready);
        sb.note_request(item);
    endtask

    task automatic load_rule(logic [3:0] slot, dev_id_t id, logic [7:0] prio);
        send('{req: REQ_LOAD, slot: slot, id: id, prio: prio});
    endtask

    // Slot and priority are don't-care on a lookup: randomise them.
    task automatic look_up(dev_id_t id);
        send('{req: REQ_LOOKUP, slot: 4'($urandom), id: id, prio: 8'($urandom)});
    endtask

    // Drop valid and hold until every owed result has arrived.
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    // Drain, then let a trailing load settle before touching the register.
    task automatic settle();
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Only called with the block idle.
    task automatic write_scan_count(logic [4:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_scan_count(value);
    endtask

    // ------------------------------------------------------------------------
    // Result side: random back-pressure, and a check of every accepted
    // result transaction.
    // ------------------------------------------------------------------------
    initial
    begin
        int hold;
        int g;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            hold = $urandom_range(1, 20);
            out_ready <= 1'b1;
            repeat (hold) @(posedge clk);
            g = rx_quiet ? 0 : gap_len();
            if (g > 0)
            begin
                out_ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            seen_report.found = found;
            seen_report.index = best_index;
            seen_report.spec  = best_spec;
            seen_report.prio  = best_prio;
            sb.check_report(seen_report);
        end
    end

    // Hard stop well beyond the slowest correct run.
    initial
    begin
        #8000000;
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        logic [4:0] phase_scan [NUM_PHASES];
        logic [7:0] prio;

        for (int k = 0; k < 4; k++)
            id_pool[k] = dev_id_t'(56'({$urandom, $urandom}));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Scan the whole table, and load every slot before
        // the first lookup so that no unwritten slot is ever read.
        write_scan_count(5'd16);
        load_rule(4'd0, '{WILD16, WILD16, WILD8, WILD8, WILD8}, 8'd0);
        load_rule(4'd1, '{16'h8086, WILD16, WILD8, WILD8, WILD8}, 8'd5);
        load_rule(4'd2, '{16'h8086, 16'h1234, WILD8, WILD8, WILD8}, 8'd3);
        // Equal priority: slot 2 must keep the win.
        load_rule(4'd3, '{16'h8086, 16'h1234, WILD8, WILD8, WILD8}, 8'd3);
        // Strictly higher priority: slot 4 overtakes.
        load_rule(4'd4, '{16'h8086, 16'h1234, WILD8, WILD8, WILD8}, 8'd9);
        load_rule(4'd5, '{16'h8086, 16'h1234, 8'h02, 8'h00, 8'h00}, 8'd255);
        load_rule(4'd6, '{16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00}, 8'd0);
        load_rule(4'd7, '{16'hFFFE, 16'hFFFE, 8'hFE, 8'hFE, 8'hFE}, 8'd128);
        load_rule(4'd8, '{WILD16, WILD16, 8'h01, 8'h06, WILD8}, 8'd1);
        load_rule(4'd9, '{WILD16, WILD16, WILD8, WILD8, 8'h01}, 8'd2);
        for (int s = 10; s < 16; s++)
            load_rule(4'(s), make_rule_id(), 8'($urandom));

        look_up('{16'h8086, 16'h1234, 8'h02, 8'h00, 8'h00});
        look_up('{16'h8086, 16'h1234, 8'h01, 8'h06, 8'h01});
        look_up('{16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00});
        look_up('{16'hFFFE, 16'hFFFE, 8'hFE, 8'hFE, 8'hFE});
        look_up('{WILD16, WILD16, WILD8, WILD8, WILD8});
        look_up('{16'h1111, 16'h2222, 8'h01, 8'h06, 8'h01});

        // Single-entry scan, zero scan (never a match), saturated scan.
        settle();
        write_scan_count(5'd1);
        look_up('{16'h8086, 16'h1234, 8'h02, 8'h00, 8'h00});
        settle();
        write_scan_count(5'd0);
        look_up('{16'h8086, 16'h1234, 8'h02, 8'h00, 8'h00});
        settle();
        write_scan_count(5'd31);
        look_up('{16'h8086, 16'h1234, 8'h01, 8'h06, 8'h01});

        // Random phases, each under its own scan count.
        phase_scan[0] = 5'd16;
        phase_scan[1] = 5'd1;
        phase_scan[2] = 5'd31;
        phase_scan[3] = 5'd8;
        phase_scan[4] = 5'd0;
        phase_scan[5] = 5'd17;
        phase_scan[6] = 5'($urandom_range(2, 15));
        phase_scan[7] = 5'd16;

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            settle();
            tx_quiet <= (p == 2 || p == 5);
            rx_quiet <= (p == 2 || p == 6);
            write_scan_count(phase_scan[p]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if ($urandom_range(0, 99) < 35)
                begin
                    // Low priorities often, to provoke ties.
                    prio = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
                    load_rule(4'($urandom_range(0, 15)), make_rule_id(), prio);
                end
                else
                    look_up(make_probe_id());
                // Pause the sender with results still owed, once per phase
                // at least.
                if (n == ITEMS_PER_PHASE / 2 || $urandom_range(0, 199) == 0)
                    hold_until_drained();
            end
        end

        settle();
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/wdms_pkg.sv
rtl/wdms_rule_mem.sv
rtl/wdms_match.sv
rtl/wdms_ctrl.sv
rtl/wildcard_driver_match_selector.sv
tb/wildcard_driver_match_selector_tb.sv
